/* src/cipm_pkg.sv */
// Package for the CPU idle power-mode controller.
// Holds the sizes, command and register codes, and the types shared between modules.
// Depends on nothing.
`default_nettype none

package cipm_pkg;

  localparam int NUM_CPUS  = 8;
  localparam int NUM_MODES = 4;

  localparam int CPU_IDX_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int MODE_IDX_W = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;

  typedef enum logic [1:0] {
    CMD_ENTER   = 2'd0,
    CMD_EXIT    = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_ENABLE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_CLUSTER = 2'd1,
    KIND_SYSTEM  = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_SIBLINGS      = 3'd0,
    REG_ENTRY_ALLOWED = 3'd1,
    REG_RESIDENCY     = 3'd2,
    REG_PSCI_CODE     = 3'd3,
    REG_KIND          = 3'd4,
    REG_ONLINE        = 3'd5,
    REG_CLUSTER_MAP   = 3'd6
  } cfg_reg_e;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [31:0] mode_siblings;
    logic [31:0] mode_entry_allowed;
    logic [63:0] mode_residency;
    logic [63:0] mode_psci_code;
    logic [7:0]  mode_kind;
    logic [7:0]  online_mask;
    logic [15:0] cpu_cluster_map;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  cpu;
    logic [31:0] base_index;
    logic [15:0] sleep_length;
    logic        cancel;
    logic [1:0]  mode_type;
    logic        system_refused;
  } req_t;

  typedef struct packed {
    logic [31:0] result_index;
    logic [3:0]  entered_modes;
    logic [3:0]  exited_modes;
    logic [7:0]  wake_cpus;
    logic        core_off;
    logic        core_on;
    logic        cluster_off;
    logic        cluster_on;
    logic [1:0]  cluster_number;
    logic        system_enter;
    logic        system_exit;
    logic        exit_cancelled;
  } rsp_t;

endpackage

`default_nettype wire

/* src/cipm_if.sv */
// Channel interfaces of the CPU idle power-mode controller: request, response and
// configuration write. Each has a source and a sink modport. No package dependency.
`default_nettype none

interface cipm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  cpu;
  logic [31:0] base_index;
  logic [15:0] sleep_length;
  logic        cancel;
  logic [1:0]  mode_type;
  logic        system_refused;

  modport source (output valid, cmd, cpu, base_index, sleep_length, cancel, mode_type,
                  system_refused, input ready);
  modport sink (input valid, cmd, cpu, base_index, sleep_length, cancel, mode_type,
                system_refused, output ready);
endinterface

interface cipm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_index;
  logic [3:0]  entered_modes;
  logic [3:0]  exited_modes;
  logic [7:0]  wake_cpus;
  logic        core_off;
  logic        core_on;
  logic        cluster_off;
  logic        cluster_on;
  logic [1:0]  cluster_number;
  logic        system_enter;
  logic        system_exit;
  logic        exit_cancelled;

  modport source (output valid, result_index, entered_modes, exited_modes, wake_cpus,
                  core_off, core_on, cluster_off, cluster_on, cluster_number,
                  system_enter, system_exit, exit_cancelled, input ready);
  modport sink (input valid, result_index, entered_modes, exited_modes, wake_cpus,
                core_off, core_on, cluster_off, cluster_on, cluster_number,
                system_enter, system_exit, exit_cancelled, output ready);
endinterface

interface cipm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/cpu_idle_power_mode_controller.sv */
// Top level of the CPU idle power-mode controller: request register, configuration
// registers and decision stage. Depends on cipm_pkg, cipm_if, cipm_cfg_regs, cipm_engine.
//
//   channel  direction  content
//   req      in         cmd, cpu, base_index, sleep_length, cancel, mode_type,
//                       system_refused
//   rsp      out        result_index, entered/exited modes, wake_cpus, power actions
//   cfg      in         index, data (seven registers, always ready)
//
// A request is registered in the request register on acceptance and its response in the
// response register; one request is taken every cycle unless the response stalls.
// The decision logic between the request and response registers sets this rate.
// A stalled response holds the decision stage; the request register, if empty, still takes one
// more request. Reset is synchronous and clears all cpu and mode state at once.
`default_nettype none

module cpu_idle_power_mode_controller
  import cipm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  cipm_req_if.sink   req,
  cipm_rsp_if.source rsp,
  cipm_cfg_if.sink   cfg
);

  cfg_t regs;
  req_t item;
  logic item_valid;
  logic advance;
  logic out_valid;
  rsp_t out_rsp;

  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.cmd            <= req.cmd;
      item.cpu            <= req.cpu;
      item.base_index     <= req.base_index;
      item.sleep_length   <= req.sleep_length;
      item.cancel         <= req.cancel;
      item.mode_type      <= req.mode_type;
      item.system_refused <= req.system_refused;
    end
  end

  cipm_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  cipm_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .regs       (regs),
    .out_ready  (rsp.ready),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp)
  );

  assign rsp.valid          = out_valid;
  assign rsp.result_index   = out_rsp.result_index;
  assign rsp.entered_modes  = out_rsp.entered_modes;
  assign rsp.exited_modes   = out_rsp.exited_modes;
  assign rsp.wake_cpus      = out_rsp.wake_cpus;
  assign rsp.core_off       = out_rsp.core_off;
  assign rsp.core_on        = out_rsp.core_on;
  assign rsp.cluster_off    = out_rsp.cluster_off;
  assign rsp.cluster_on     = out_rsp.cluster_on;
  assign rsp.cluster_number = out_rsp.cluster_number;
  assign rsp.system_enter   = out_rsp.system_enter;
  assign rsp.system_exit    = out_rsp.system_exit;
  assign rsp.exit_cancelled = out_rsp.exit_cancelled;

endmodule

`default_nettype wire

/* src/cipm_cfg_regs.sv */
// Configuration register file of the CPU idle power-mode controller.
// Depends on cipm_pkg and the cipm_cfg_if interface.
`default_nettype none

module cipm_cfg_regs
  import cipm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  cipm_cfg_if.sink  cfg,
  output cfg_t      regs
);

  cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      case (cfg.index)
        REG_SIBLINGS:      regs_next.mode_siblings      = cfg.data[31:0];
        REG_ENTRY_ALLOWED: regs_next.mode_entry_allowed = cfg.data[31:0];
        REG_RESIDENCY:     regs_next.mode_residency     = cfg.data;
        REG_PSCI_CODE:     regs_next.mode_psci_code     = cfg.data;
        REG_KIND:          regs_next.mode_kind          = cfg.data[7:0];
        REG_ONLINE:        regs_next.online_mask        = cfg.data[7:0];
        REG_CLUSTER_MAP:   regs_next.cpu_cluster_map    = cfg.data[15:0];
        default:           regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode_siblings      <= '0;
      regs.mode_entry_allowed <= '0;
      regs.mode_residency     <= '0;
      regs.mode_psci_code     <= '0;
      regs.mode_kind          <= '0;
      regs.online_mask        <= 8'hFF;
      regs.cpu_cluster_map    <= '0;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

/* src/cipm_engine.sv */
// Decision stage of the CPU idle power-mode controller: per-cpu and per-mode state,
// the entry, exit and disable checks, and the response register.
// Depends on cipm_pkg.
`default_nettype none

module cipm_engine
  import cipm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  req_t      item,
  input  cfg_t      regs,
  input  wire logic out_ready,
  output logic      advance,
  output logic      out_valid,
  output rsp_t      out_rsp
);

  logic                 cpu_down [NUM_CPUS];
  logic [15:0]          cpu_sleep [NUM_CPUS];
  logic [NUM_MODES-1:0] mode_down;
  logic [7:0]           mode_count [NUM_MODES];

  logic [NUM_MODES-1:0] mode_down_next;
  logic [7:0]           mode_count_next [NUM_MODES];
  rsp_t                 rsp_next;

  logic [CPU_IDX_W-1:0] cpu_idx;
  logic                 in_range;
  logic                 is_enter;
  logic                 is_exit;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign cpu_idx  = item.cpu[CPU_IDX_W-1:0];
  assign in_range = (int'(item.cpu) < NUM_CPUS);
  assign is_enter = in_range && (item.cmd == CMD_ENTER);
  assign is_exit  = in_range && (item.cmd == CMD_EXIT);

  always_comb begin
    logic [NUM_CPUS-1:0]  members;
    logic [NUM_CPUS-1:0]  allowed;
    logic [NUM_CPUS-1:0]  wake;
    logic [NUM_MODES-1:0] entered;
    logic [NUM_MODES-1:0] exited;
    logic [15:0]          residency;
    logic [1:0]           kind;
    logic                 sib_ok;
    logic                 down_c;
    logic [15:0]          sleep_c;

    rsp_next        = '0;
    mode_down_next  = mode_down;
    mode_count_next = mode_count;
    wake            = '0;
    entered         = '0;
    exited          = '0;

    if (in_range) begin
      rsp_next.cluster_number = regs.cpu_cluster_map[2*cpu_idx +: 2];
    end
    if (is_enter) begin
      rsp_next.core_off     = 1'b1;
      rsp_next.result_index = item.base_index;
    end
    if (is_exit) begin
      rsp_next.core_on = 1'b1;
    end

    for (int m = 0; m < NUM_MODES; m++) begin
      members   = regs.mode_siblings[8*m +: NUM_CPUS];
      allowed   = regs.mode_entry_allowed[8*m +: NUM_CPUS];
      residency = regs.mode_residency[16*m +: 16];
      kind      = regs.mode_kind[2*m +: 2];

      sib_ok = 1'b1;
      for (int c = 0; c < NUM_CPUS; c++) begin
        down_c  = cpu_down[c] || (is_enter && (cpu_idx == CPU_IDX_W'(c)));
        sleep_c = (is_enter && (cpu_idx == CPU_IDX_W'(c))) ? item.sleep_length
                                                            : cpu_sleep[c];
        if (members[c] && regs.online_mask[c] && (!down_c || (sleep_c < residency))) begin
          sib_ok = 1'b0;
        end
      end

      if (is_enter && members[cpu_idx] && (mode_count[m] == 8'd0) && allowed[cpu_idx]
          && sib_ok && !((kind == KIND_SYSTEM) && item.system_refused)) begin
        entered[m]        = 1'b1;
        mode_down_next[m] = 1'b1;
        rsp_next.result_index = rsp_next.result_index
                                | {16'd0, regs.mode_psci_code[16*m +: 16]};
        if (kind == KIND_CLUSTER) begin
          rsp_next.cluster_off = 1'b1;
        end
        if (kind == KIND_SYSTEM) begin
          rsp_next.system_enter = 1'b1;
        end
      end

      if (is_exit && members[cpu_idx] && mode_down[m]) begin
        exited[m]         = 1'b1;
        mode_down_next[m] = 1'b0;
        if (kind == KIND_CLUSTER) begin
          rsp_next.cluster_on = 1'b1;
        end
        if (kind == KIND_SYSTEM) begin
          rsp_next.system_exit    = 1'b1;
          rsp_next.exit_cancelled = item.cancel;
        end
      end

      if (in_range && members[cpu_idx] && (kind == item.mode_type)) begin
        if ((item.cmd == CMD_DISABLE) && (mode_count[m] != COUNT_MAX)) begin
          mode_count_next[m] = mode_count[m] + 8'd1;
          if (mode_count[m] == 8'd0) begin
            wake = wake | (members & regs.online_mask[NUM_CPUS-1:0]);
          end
        end else if ((item.cmd == CMD_ENABLE) && (mode_count[m] != 8'd0)) begin
          mode_count_next[m] = mode_count[m] - 8'd1;
        end
      end
    end

    rsp_next.entered_modes = 4'(entered);
    rsp_next.exited_modes  = 4'(exited);
    rsp_next.wake_cpus     = 8'(wake);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        cpu_down[c]  <= 1'b0;
        cpu_sleep[c] <= '0;
      end
      for (int m = 0; m < NUM_MODES; m++) begin
        mode_count[m] <= '0;
      end
      mode_down <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        if (is_enter) begin
          cpu_down[cpu_idx]  <= 1'b1;
          cpu_sleep[cpu_idx] <= item.sleep_length;
        end
        if (is_exit) begin
          cpu_down[cpu_idx] <= 1'b0;
        end
        mode_down  <= mode_down_next;
        mode_count <= mode_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* src/cipm_checker.sv */
// Port-level checks for the CPU idle power-mode controller, bound to its top level.
// Depends on the cipm_if interfaces only through the bound top-level ports.
`default_nettype none

module cipm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] rsp_result_index,
  input wire logic [3:0]  rsp_entered_modes,
  input wire logic [3:0]  rsp_exited_modes,
  input wire logic        rsp_core_off,
  input wire logic        rsp_core_on,
  input wire logic        rsp_system_exit,
  input wire logic        rsp_exit_cancelled
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("Response valid after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_index))
    else $error("Stalled response changed.");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_core_off && rsp_core_on))
    else $error("Core powered off and on in one response.");

  a_enter_exit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_entered_modes != 4'd0) |-> rsp_core_off && (rsp_exited_modes == 4'd0))
    else $error("Modes entered without an idle entry.");

  a_cancel: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_exit_cancelled |-> rsp_system_exit && rsp_core_on)
    else $error("Cancel flag without a system exit.");

endmodule

bind cpu_idle_power_mode_controller cipm_checker u_cipm_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_result_index   (rsp.result_index),
  .rsp_entered_modes  (rsp.entered_modes),
  .rsp_exited_modes   (rsp.exited_modes),
  .rsp_core_off       (rsp.core_off),
  .rsp_core_on        (rsp.core_on),
  .rsp_system_exit    (rsp.system_exit),
  .rsp_exit_cancelled (rsp.exit_cancelled)
);

`default_nettype wire

/* bench/cpu_idle_power_mode_controller_test.sv */
// Self-checking bench for the cpu idle power-mode controller: directed and random requests,
// with a predictor of mode entry, exit and disable counts. Needs cipm_pkg, the channel
// interfaces and the controller itself.

module cpu_idle_power_mode_controller_test;
  import cipm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;

  cipm_req_if req_ch ();
  cipm_rsp_if rsp_ch ();
  cipm_cfg_if cfg_ch ();

  cpu_idle_power_mode_controller dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  cfg_t     shadow_cfg;
  bit       shadow_cpu_down [NUM_CPUS];
  bit [15:0] shadow_cpu_sleep [NUM_CPUS];
  bit       shadow_mode_down [NUM_MODES];
  bit [7:0] shadow_disable_cnt [NUM_MODES];

  rsp_t pending_responses [$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  config_writes = 0;
  int  responses_checked = 0;
  int  mode_entries = 0;
  int  cluster_power_offs = 0;
  int  system_entries = 0;
  int  quiet_cycles = 0;
  int  hold_off_cycles = 0;
  bit  send_idling = 1'b1;
  bit  accept_idling = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] mode_members(int m);
    return shadow_cfg.mode_siblings[8*m +: 8];
  endfunction

  function automatic bit siblings_asleep(int m);
    logic [7:0]  group;
    logic [15:0] need;
    group = mode_members(m) & shadow_cfg.online_mask;
    need  = shadow_cfg.mode_residency[16*m +: 16];
    for (int c = 0; c < NUM_CPUS; c++) begin
      if (group[c] && (!shadow_cpu_down[c] || shadow_cpu_sleep[c] < need)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic rsp_t predict_power_response(req_t r);
    rsp_t       o;
    kind_e      kind;
    logic [7:0] group;
    o = '0;
    o.cluster_number = shadow_cfg.cpu_cluster_map[2*r.cpu +: 2];
    case (cmd_e'(r.cmd))
      CMD_ENTER: begin
        o.core_off = 1'b1;
        shadow_cpu_down[r.cpu]  = 1'b1;
        shadow_cpu_sleep[r.cpu] = r.sleep_length;
        o.result_index = r.base_index;
        for (int m = 0; m < NUM_MODES; m++) begin
          kind  = kind_e'(shadow_cfg.mode_kind[2*m +: 2]);
          group = mode_members(m);
          if (group[r.cpu] && shadow_disable_cnt[m] == 8'd0 &&
              shadow_cfg.mode_entry_allowed[8*m + r.cpu] && siblings_asleep(m) &&
              !(kind == KIND_SYSTEM && r.system_refused)) begin
            if (kind == KIND_CLUSTER) o.cluster_off = 1'b1;
            if (kind == KIND_SYSTEM) o.system_enter = 1'b1;
            shadow_mode_down[m] = 1'b1;
            o.entered_modes[m] = 1'b1;
            o.result_index |= {16'h0000, shadow_cfg.mode_psci_code[16*m +: 16]};
          end
        end
      end
      CMD_EXIT: begin
        for (int m = 0; m < NUM_MODES; m++) begin
          kind  = kind_e'(shadow_cfg.mode_kind[2*m +: 2]);
          group = mode_members(m);
          if (group[r.cpu] && shadow_mode_down[m]) begin
            shadow_mode_down[m] = 1'b0;
            o.exited_modes[m] = 1'b1;
            if (kind == KIND_CLUSTER) o.cluster_on = 1'b1;
            if (kind == KIND_SYSTEM) begin
              o.system_exit    = 1'b1;
              o.exit_cancelled = r.cancel;
            end
          end
        end
        shadow_cpu_down[r.cpu] = 1'b0;
        o.core_on = 1'b1;
      end
      default: begin
        for (int m = 0; m < NUM_MODES; m++) begin
          group = mode_members(m);
          if (group[r.cpu] && shadow_cfg.mode_kind[2*m +: 2] == r.mode_type) begin
            if (cmd_e'(r.cmd) == CMD_DISABLE) begin
              if (shadow_disable_cnt[m] < COUNT_MAX) begin
                shadow_disable_cnt[m]++;
                if (shadow_disable_cnt[m] == 8'd1) o.wake_cpus |= group & shadow_cfg.online_mask;
              end
            end else if (shadow_disable_cnt[m] > 8'd0) begin
              shadow_disable_cnt[m]--;
            end
          end
        end
      end
    endcase
    if (o.entered_modes != 4'd0) mode_entries++;
    if (o.cluster_off) cluster_power_offs++;
    if (o.system_enter) system_entries++;
    return o;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  task automatic send_request(cmd_e c, logic [2:0] cpu, logic [31:0] base = '0,
                              logic [15:0] sleep = '0, logic cancel = 1'b0,
                              logic [1:0] mtype = 2'd0, logic refused = 1'b0);
    req_t r;
    r.cmd = c;
    r.cpu = cpu;
    r.base_index = base;
    r.sleep_length = sleep;
    r.cancel = cancel;
    r.mode_type = mtype;
    r.system_refused = refused;
    @(negedge clk);
    while (send_idling && $urandom_range(99) < 18) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid          = 1'b1;
    req_ch.cmd            = r.cmd;
    req_ch.cpu            = r.cpu;
    req_ch.base_index     = r.base_index;
    req_ch.sleep_length   = r.sleep_length;
    req_ch.cancel         = r.cancel;
    req_ch.mode_type      = r.mode_type;
    req_ch.system_refused = r.system_refused;
    do @(posedge clk); while (!req_ch.ready);
    pending_responses.push_back(predict_power_response(r));
    requests_sent++;
  endtask

  task automatic send_noise();
    send_request(cmd_e'($urandom_range(3)), 3'($urandom), $urandom, 16'($urandom),
                 1'($urandom), 2'($urandom), 1'($urandom));
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SIBLINGS:      shadow_cfg.mode_siblings      = value[31:0];
      REG_ENTRY_ALLOWED: shadow_cfg.mode_entry_allowed = value[31:0];
      REG_RESIDENCY:     shadow_cfg.mode_residency     = value;
      REG_PSCI_CODE:     shadow_cfg.mode_psci_code     = value;
      REG_KIND:          shadow_cfg.mode_kind          = value[7:0];
      REG_ONLINE:        shadow_cfg.online_mask        = value[7:0];
      REG_CLUSTER_MAP:   shadow_cfg.cpu_cluster_map    = value[15:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic load_settings(cfg_t c);
    wait_until_drained();
    write_register(REG_SIBLINGS,      {32'h0, c.mode_siblings});
    write_register(REG_ENTRY_ALLOWED, {32'h0, c.mode_entry_allowed});
    write_register(REG_RESIDENCY,     c.mode_residency);
    write_register(REG_PSCI_CODE,     c.mode_psci_code);
    write_register(REG_KIND,          {56'h0, c.mode_kind});
    write_register(REG_ONLINE,        {56'h0, c.online_mask});
    write_register(REG_CLUSTER_MAP,   {48'h0, c.cpu_cluster_map});
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    for (int m = 0; m < NUM_MODES; m++) begin
      case ($urandom_range(3))
        0: c.mode_siblings[8*m +: 8] = 8'h0F;
        1: c.mode_siblings[8*m +: 8] = 8'hF0;
        2: c.mode_siblings[8*m +: 8] = 8'hFF;
        default: c.mode_siblings[8*m +: 8] = 8'($urandom);
      endcase
      c.mode_residency[16*m +: 16] = ($urandom_range(7) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(300));
    end
    c.mode_entry_allowed = $urandom | $urandom;
    c.mode_psci_code     = {$urandom, $urandom};
    c.mode_kind          = 8'($urandom);
    c.online_mask        = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF;
    c.cpu_cluster_map    = 16'($urandom);
    return c;
  endfunction

  // Members of one mode go idle in turn, so that the mode can actually be entered.
  task automatic run_mode_sequence();
    int         m;
    int         first;
    int         c;
    logic [7:0] group;
    logic [1:0] kind;
    m = $urandom_range(NUM_MODES - 1);
    group = mode_members(m);
    kind  = shadow_cfg.mode_kind[2*m +: 2];
    if (group == 8'h00) begin
      send_noise();
      return;
    end
    first = $urandom_range(NUM_CPUS - 1);
    while (!group[first]) first = (first + 1) % NUM_CPUS;
    for (int i = 0; i < 4 && shadow_disable_cnt[m] != 8'd0; i++)
      send_request(CMD_ENABLE, 3'(first), $urandom, 16'($urandom), 1'($urandom), kind);
    for (int i = 0; i < NUM_CPUS; i++) begin
      c = (first + i) % NUM_CPUS;
      if (group[c])
        send_request(CMD_ENTER, 3'(c), $urandom,
                     ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(600)),
                     1'($urandom), 2'($urandom), $urandom_range(3) == 0);
    end
    if ($urandom_range(1) == 1) begin
      first = $urandom_range(NUM_CPUS - 1);
      for (int i = 0; i < NUM_CPUS; i++) begin
        c = (first + i) % NUM_CPUS;
        if (group[c])
          send_request(CMD_EXIT, 3'(c), $urandom, 16'($urandom), 1'($urandom), 2'($urandom));
      end
    end
  endtask

  task automatic test_reset_state();
    send_request(CMD_ENTER, 3'd0, 32'h0000_0000, 16'h0000);
    send_request(CMD_ENTER, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, KIND_OTHER, 1'b1);
    send_request(CMD_EXIT, 3'd0, 32'h0, 16'h0, 1'b1);
    send_request(CMD_EXIT, 3'd7);
    send_request(CMD_DISABLE, 3'd3, 32'h0, 16'h0, 1'b0, KIND_PLAIN);
    send_request(CMD_ENABLE, 3'd3, 32'h0, 16'h0, 1'b0, KIND_PLAIN);
  endtask

  // Plain mode over cpus 0-1, cluster over 0-3 (only cpu 3 may trigger it), system over
  // all cpus, and a kind-three mode over cpus 4-7 that needs the longest sleep.
  task automatic test_mode_entry();
    cfg_t c;
    c.mode_siblings      = 32'hF0FF_0F03;
    c.mode_entry_allowed = 32'hFFFF_08FF;
    c.mode_residency     = 64'hFFFF_0064_0064_0000;
    c.mode_psci_code     = 64'h4000_0300_0020_0001;
    c.mode_kind          = 8'hE4;
    c.online_mask        = 8'hFF;
    c.cpu_cluster_map    = 16'hE41B;
    load_settings(c);
    send_request(CMD_ENTER, 3'd0, 32'h1000_0000, 16'd150);
    send_request(CMD_ENTER, 3'd1, 32'h1000_0000, 16'd150);
    send_request(CMD_ENTER, 3'd2, 32'h2000_0000, 16'd200);
    send_request(CMD_ENTER, 3'd3, 32'h3000_0000, 16'd200);
    send_request(CMD_ENTER, 3'd3, 32'h3000_0000, 16'd200);
    for (int i = 4; i < NUM_CPUS; i++)
      send_request(CMD_ENTER, 3'(i), 32'h0, 16'hFFFF);
    send_request(CMD_ENTER, 3'd7, 32'h8000_0000, 16'hFFFF, 1'b0, KIND_PLAIN, 1'b1);
    send_request(CMD_ENTER, 3'd7, 32'h8000_0000, 16'hFFFF);
    send_request(CMD_EXIT, 3'd7, 32'h0, 16'h0, 1'b1);
    send_request(CMD_EXIT, 3'd0);
    send_request(CMD_DISABLE, 3'd2, 32'h0, 16'h0, 1'b0, KIND_CLUSTER);
    send_request(CMD_DISABLE, 3'd2, 32'h0, 16'h0, 1'b0, KIND_CLUSTER);
    send_request(CMD_ENTER, 3'd3, 32'h0, 16'd300);
    send_request(CMD_ENABLE, 3'd2, 32'h0, 16'h0, 1'b0, KIND_CLUSTER);
    send_request(CMD_ENABLE, 3'd2, 32'h0, 16'h0, 1'b0, KIND_CLUSTER);
    send_request(CMD_DISABLE, 3'd5, 32'h0, 16'h0, 1'b0, KIND_OTHER);
    send_request(CMD_ENTER, 3'd5, 32'h0, 16'hFFFF);
    send_request(CMD_ENABLE, 3'd5, 32'h0, 16'h0, 1'b0, KIND_OTHER);
    // With cpus 0 and 1 offline the plain mode has no online member and passes.
    wait_until_drained();
    write_register(REG_ONLINE, 64'h0000_0000_0000_00F0);
    send_request(CMD_ENTER, 3'd0, 32'h0, 16'h0);
    send_request(CMD_EXIT, 3'd0);
  endtask

  task automatic test_disable_count_limits();
    for (int i = 0; i < 257; i++)
      send_request(CMD_DISABLE, 3'd0, 32'h0, 16'h0, 1'b0, KIND_PLAIN);
    send_request(CMD_ENTER, 3'd1, 32'h0, 16'hFFFF);
    for (int i = 0; i < 257; i++)
      send_request(CMD_ENABLE, 3'd0, 32'h0, 16'h0, 1'b0, KIND_PLAIN);
    send_request(CMD_ENTER, 3'd1, 32'h0, 16'hFFFF);
  endtask

  task automatic test_response_backpressure();
    wait_until_drained();
    send_idling = 1'b0;
    hold_off_cycles = 60;
    for (int i = 0; i < 24; i++) send_noise();
    send_idling = 1'b1;
  endtask

  task automatic test_random_traffic();
    int goal;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_settings('1);
        1: load_settings('0);
        default: load_settings(random_settings());
      endcase
      send_idling   = (phase != 3);
      accept_idling = (phase != 3);
      goal = requests_sent + ((phase == 3) ? 24 : 4);
      while (requests_sent < goal) begin
        if ($urandom_range(9) < 7) run_mode_sequence();
        else send_noise();
      end
    end
    send_idling   = 1'b1;
    accept_idling = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.cpu = '0;
    req_ch.base_index = '0;
    req_ch.sleep_length = '0;
    req_ch.cancel = 1'b0;
    req_ch.mode_type = '0;
    req_ch.system_refused = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    shadow_cfg = '0;
    shadow_cfg.online_mask = 8'hFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_mode_entry();
    test_disable_count_limits();
    test_response_backpressure();
    test_random_traffic();
    wait_until_drained();

    $display("%0d requests and %0d register writes, %0d responses checked, %0d mismatches",
             requests_sent, config_writes, responses_checked, mismatches);
    $display("%0d requests entered a mode, %0d cluster power-offs, %0d system entries",
             mode_entries, cluster_power_offs, system_entries);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        hold_off_cycles--;
      end else begin
        rsp_ch.ready = !(accept_idling && $urandom_range(99) < 18);
      end
    end
  end

  always @(posedge clk) begin : check_response
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = pending_responses.pop_front();
        responses_checked++;
        compare_field("result_index",   rsp_ch.result_index,   want.result_index);
        compare_field("entered_modes",  rsp_ch.entered_modes,  want.entered_modes);
        compare_field("exited_modes",   rsp_ch.exited_modes,   want.exited_modes);
        compare_field("wake_cpus",      rsp_ch.wake_cpus,      want.wake_cpus);
        compare_field("core_off",       rsp_ch.core_off,       want.core_off);
        compare_field("core_on",        rsp_ch.core_on,        want.core_on);
        compare_field("cluster_off",    rsp_ch.cluster_off,    want.cluster_off);
        compare_field("cluster_on",     rsp_ch.cluster_on,     want.cluster_on);
        compare_field("cluster_number", rsp_ch.cluster_number, want.cluster_number);
        compare_field("system_enter",   rsp_ch.system_enter,   want.system_enter);
        compare_field("system_exit",    rsp_ch.system_exit,    want.system_exit);
        compare_field("exit_cancelled", rsp_ch.exit_cancelled, want.exit_cancelled);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, pending_responses.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* files.f */
src/cipm_pkg.sv
src/cipm_if.sv
src/cipm_cfg_regs.sv
src/cipm_engine.sv
src/cpu_idle_power_mode_controller.sv
src/cipm_checker.sv
bench/cpu_idle_power_mode_controller_test.sv
